/* sv/chsi_pkg.sv */
package chsi_pkg;

  // Component index width is fixed by the item format.
  localparam int COMP_W = 3;

  typedef logic [COMP_W-1:0] comp_t;

  // Per-item control tag that rides along the pipeline.
  typedef struct packed {
    logic  ok;
    logic  is_time;
    comp_t comp;
  } tag_t;

endpackage

/* sv/chsi_in_if.sv */
interface chsi_in_if #(
  parameter int DATA_WIDTH = 32
);
  import chsi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] start_time;
  logic signed [DATA_WIDTH-1:0] end_time;
  logic signed [DATA_WIDTH-1:0] time_offset;
  comp_t                        component_index;
  logic signed [DATA_WIDTH-1:0] start_value;
  logic signed [DATA_WIDTH-1:0] end_value;
  logic signed [DATA_WIDTH-1:0] start_slope;
  logic signed [DATA_WIDTH-1:0] end_slope;

  modport source (
    output valid, start_time, end_time, time_offset, component_index,
    output start_value, end_value, start_slope, end_slope,
    input  ready
  );

  modport sink (
    input  valid, start_time, end_time, time_offset, component_index,
    input  start_value, end_value, start_slope, end_slope,
    output ready
  );

endinterface

/* sv/chsi_out_if.sv */
interface chsi_out_if #(
  parameter int DATA_WIDTH = 32
);
  import chsi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] interpolated_value;
  logic                         in_range;
  logic                         saturated;
  comp_t                        component_out;

  modport source (
    output valid, interpolated_value, in_range, saturated, component_out,
    input  ready
  );

  modport sink (
    input  valid, interpolated_value, in_range, saturated, component_out,
    output ready
  );

endinterface

/* sv/chsi_div.sv */
module chsi_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic [FRAC_BITS:0]    en,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output logic [FRAC_BITS:0]    quo
);

  localparam int W = DATA_WIDTH;
  localparam int N = FRAC_BITS + 1;

  // Partial remainder and divisor for every stage but the last one.
  logic [W-1:0] rem_r [N-1];
  logic [W-1:0] den_r [N-1];
  logic [N-1:0] q_r   [N];

  // Restoring division, one quotient bit per stage, most significant bit first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W:0]   rin;
    logic [W-1:0] dv;
    logic [N-1:0] qin;
    logic [W+1:0] diff;
    logic         qbit;

    if (k == 0) begin : g_first
      assign rin = {1'b0, num};
      assign dv  = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = {rem_r[k-1], 1'b0};
      assign dv  = den_r[k-1];
      assign qin = q_r[k-1];
    end

    assign diff = {1'b0, rin} - {2'b00, dv};
    assign qbit = ~diff[W+1];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        q_r[k] <= {qin[N-2:0], qbit};
      end
    end

    // The last stage needs only the quotient.
    if (k < N - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= qbit ? diff[W-1:0] : rin[W-1:0];
          den_r[k] <= dv;
        end
      end
    end
  end

  assign quo = q_r[N-1];

endmodule

/* sv/chsi_basis.sv */
module chsi_basis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic [FRAC_BITS:0]          frac,
  output logic signed [FRAC_BITS+2:0] h00,
  output logic signed [FRAC_BITS+2:0] h10,
  output logic signed [FRAC_BITS+2:0] h01,
  output logic signed [FRAC_BITS+2:0] h11
);

  localparam int F = FRAC_BITS;

  localparam logic signed [F+2:0] ONE = {3'b001, {F{1'b0}}};

  logic [2*F+1:0]     sq;
  logic [2*F+1:0]     cu;
  logic [F:0]         t2_a_r;
  logic [F:0]         f_a_r;
  logic [F:0]         t3_b_r;
  logic [F:0]         t2_b_r;
  logic [F:0]         f_b_r;
  logic signed [F+2:0] t2s;
  logic signed [F+2:0] t3s;
  logic signed [F+2:0] fs;
  logic signed [F+2:0] h00_r;
  logic signed [F+2:0] h10_r;
  logic signed [F+2:0] h01_r;
  logic signed [F+2:0] h11_r;

  // Square of the fraction, truncated back to F fractional bits.
  assign sq = frac * frac;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t2_a_r <= sq[2*F:F];
      f_a_r  <= frac;
    end
  end

  // Cube from the truncated square.
  assign cu = t2_a_r * f_a_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t3_b_r <= cu[2*F:F];
      t2_b_r <= t2_a_r;
      f_b_r  <= f_a_r;
    end
  end

  // Basis polynomials; factors of two and three are shifts and adds.
  assign t2s = {2'b00, t2_b_r};
  assign t3s = {2'b00, t3_b_r};
  assign fs  = {2'b00, f_b_r};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      h00_r <= ONE - (t2s + (t2s <<< 1)) + (t3s <<< 1);
      h10_r <= fs - (t2s <<< 1) + t3s;
      h01_r <= t3s - t2s;
      h11_r <= t2s + (t2s <<< 1) - (t3s <<< 1);
    end
  end

  assign h00 = h00_r;
  assign h10 = h10_r;
  assign h01 = h01_r;
  assign h11 = h11_r;

endmodule

/* sv/chsi_mac.sv */
module chsi_mac #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic signed [FRAC_BITS+2:0]    h00,
  input  logic signed [FRAC_BITS+2:0]    h10,
  input  logic signed [FRAC_BITS+2:0]    h01,
  input  logic signed [FRAC_BITS+2:0]    h11,
  input  chsi_pkg::tag_t                 tag,
  input  logic [DATA_WIDTH:0]            tsum,
  input  logic [DATA_WIDTH-1:0]          v0,
  input  logic [DATA_WIDTH-1:0]          v1,
  input  logic [2*DATA_WIDTH-FRAC_BITS:0] p0,
  input  logic [2*DATA_WIDTH-FRAC_BITS:0] p1,
  output logic [DATA_WIDTH-1:0]          value,
  output logic                           in_range,
  output logic                           saturated,
  output chsi_pkg::comp_t                comp_out
);
  import chsi_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W + 1 - F;
  localparam int VPW = F + 3 + W;
  localparam int PPW = F + 3 + PW;
  localparam int SW  = PW + 5;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [VPW-1:0] m00_r;
  logic signed [PPW-1:0] m10_r;
  logic signed [PPW-1:0] m01_r;
  logic signed [VPW-1:0] m11_r;
  tag_t                  tag_a_r;
  logic [W:0]            tsum_a_r;

  logic signed [W+2:0]   t00;
  logic signed [PW+2:0]  t10;
  logic signed [PW+2:0]  t01;
  logic signed [W+2:0]   t11;
  logic signed [SW-1:0]  sum_c;
  logic [SW-W:0]         sum_top;
  logic                  sum_fits;
  logic                  tsum_fits;

  logic [W-1:0]          value_nxt;
  logic                  sat_nxt;
  logic [W-1:0]          value_r;
  logic                  rng_r;
  logic                  sat_r;
  comp_t                 comp_r;

  // Four weighted products, one multiplier each.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m00_r    <= h00 * $signed(v0);
      m10_r    <= h10 * $signed(p0);
      m01_r    <= h01 * $signed(p1);
      m11_r    <= h11 * $signed(v1);
      tag_a_r  <= tag;
      tsum_a_r <= tsum;
    end
  end

  // Each product is floored back to F fractional bits, then the terms are summed.
  assign t00   = m00_r[VPW-1:F];
  assign t10   = m10_r[PPW-1:F];
  assign t01   = m01_r[PPW-1:F];
  assign t11   = m11_r[VPW-1:F];
  assign sum_c = SW'(t00) + SW'(t10) + SW'(t01) + SW'(t11);

  // A value fits when all bits above the word's sign bit copy it.
  assign sum_top   = sum_c[SW-1:W-1];
  assign sum_fits  = (&sum_top) | ~(|sum_top);
  assign tsum_fits = tsum_a_r[W] == tsum_a_r[W-1];

  // Result selection and clipping.
  always_comb begin
    value_nxt = '0;
    sat_nxt   = 1'b0;
    if (tag_a_r.ok) begin
      if (tag_a_r.is_time) begin
        if (tsum_fits) begin
          value_nxt = tsum_a_r[W-1:0];
        end else begin
          sat_nxt   = 1'b1;
          value_nxt = tsum_a_r[W] ? MINV : MAXV;
        end
      end else begin
        if (sum_fits) begin
          value_nxt = sum_c[W-1:0];
        end else begin
          sat_nxt   = 1'b1;
          value_nxt = sum_c[SW-1] ? MINV : MAXV;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      value_r <= value_nxt;
      rng_r   <= tag_a_r.ok;
      sat_r   <= sat_nxt;
      comp_r  <= tag_a_r.comp;
    end
  end

  assign value     = value_r;
  assign in_range  = rng_r;
  assign saturated = sat_r;
  assign comp_out  = comp_r;

endmodule

/* sv/cubic_hermite_step_interpolator.sv */
// Cubic Hermite step interpolator.
// Input channel in_bus carries one state component per beat: step start and
// end times, a time offset, the component's end values and end slopes, and
// its component index. Output channel out_bus returns one beat per input
// beat, in order: the interpolated value, the range flag, the saturation flag
// and the echoed component index. Both channels are valid/ready; a beat moves
// at a rising edge with valid and ready high.
// Throughput is one beat per cycle while out_bus is ready. The pipeline is a
// decode stage, then the fraction divider, which resolves one quotient bit
// per stage over FRAC_BITS + 1 stages, then three basis stages and two
// product/sum stages.
// Every stage has its own valid bit and holds while it and every later stage
// are full and out_bus is not ready, so when out_bus is stalled the input
// keeps accepting beats until all stages are occupied; nothing is dropped or
// repeated.
// Reset (rst_n low, synchronous) empties the pipeline and drops out_bus.valid;
// there is no other state to clear.
module cubic_hermite_step_interpolator #(
  parameter int DATA_WIDTH     = 32,
  parameter int FRAC_BITS      = 16,
  parameter int NUM_COMPONENTS = 8
) (
  input logic         clk,
  input logic         rst_n,
  chsi_in_if.sink     in_bus,
  chsi_out_if.source  out_bus
);
  import chsi_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int PW     = 2 * W + 1 - F;
  localparam int SIDE_N = F + 4;
  localparam int NST    = F + 7;

  typedef struct packed {
    tag_t          tag;
    logic [W:0]    tsum;
    logic [W-1:0]  v0;
    logic [W-1:0]  v1;
    logic [PW-1:0] p0;
    logic [PW-1:0] p1;
  } side_t;

  logic [NST-1:0]      vld_r;
  logic [NST-1:0]      vld_nxt;
  logic [NST-1:0]      en;

  logic signed [W:0]   ts_x;
  logic signed [W:0]   te_x;
  logic signed [W:0]   to_x;
  logic signed [W:0]   dt_c;
  logic signed [W:0]   dtn_c;
  logic [W-1:0]        to_u;
  logic [W-1:0]        ad_c;
  logic [W-1:0]        ao_c;

  logic signed [W:0]   dt_r;
  logic [W-1:0]        ad_r;
  logic [W-1:0]        ao_r;
  logic                to_neg_r;
  logic                to_zero_r;
  comp_t               comp_r;
  logic [W:0]          tsum_r;
  logic [W-1:0]        v0_r;
  logic [W-1:0]        v1_r;
  logic signed [W-1:0] s0_r;
  logic signed [W-1:0] s1_r;

  logic signed [2*W:0] p0_full;
  logic signed [2*W:0] p1_full;
  logic                ok_c;
  side_t               side_nxt;
  side_t               side_r [1:SIDE_N];

  logic [F:0]          frac;
  logic signed [F+2:0] h00;
  logic signed [F+2:0] h10;
  logic signed [F+2:0] h01;
  logic signed [F+2:0] h11;
  logic [W-1:0]        value;

  // Stage handshake: a stage may load when it or any later stage is empty,
  // or when the output beat is being taken.
  always_comb begin
    for (int g = 0; g < NST; g++) begin
      en[g] = out_bus.ready | (|((~vld_r) >> g));
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_bus.valid;
    end
    for (int g = 1; g < NST; g++) begin
      if (en[g]) begin
        vld_nxt[g] = vld_r[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_bus.ready  = en[0];
  assign out_bus.valid = vld_r[NST-1];

  // Decode stage: interval, magnitudes for the divider and the time sum.
  assign ts_x  = (W+1)'(in_bus.start_time);
  assign te_x  = (W+1)'(in_bus.end_time);
  assign to_x  = (W+1)'(in_bus.time_offset);
  assign dt_c  = te_x - ts_x;
  assign dtn_c = ts_x - te_x;
  assign ad_c  = dt_c[W] ? dtn_c[W-1:0] : dt_c[W-1:0];
  assign to_u  = in_bus.time_offset;
  assign ao_c  = to_u[W-1] ? (~to_u + W'(1)) : to_u;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r      <= dt_c;
      ad_r      <= ad_c;
      ao_r      <= ao_c;
      to_neg_r  <= to_u[W-1];
      to_zero_r <= (to_u == '0);
      comp_r    <= in_bus.component_index;
      tsum_r    <= ts_x + to_x;
      v0_r      <= in_bus.start_value;
      v1_r      <= in_bus.end_value;
      s0_r      <= in_bus.start_slope;
      s1_r      <= in_bus.end_slope;
    end
  end

  // First divider stage: exact range test and the slope-times-interval products.
  assign ok_c = (dt_r != '0) && (int'(comp_r) < NUM_COMPONENTS) &&
                (to_zero_r || ((to_neg_r == dt_r[W]) && (ao_r <= ad_r)));
  assign p0_full = dt_r * s0_r;
  assign p1_full = dt_r * s1_r;

  always_comb begin
    side_nxt.tag.ok      = ok_c;
    side_nxt.tag.is_time = (comp_r == '0);
    side_nxt.tag.comp    = comp_r;
    side_nxt.tsum        = tsum_r;
    side_nxt.v0          = v0_r;
    side_nxt.v1          = v1_r;
    side_nxt.p0          = p0_full[2*W:F];
    side_nxt.p1          = p1_full[2*W:F];
  end

  // Side data travels next to the divider and basis stages.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1] <= side_nxt;
    end
    for (int g = 2; g <= SIDE_N; g++) begin
      if (en[g]) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  chsi_div #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F)
  ) u_div (
    .clk (clk),
    .en  (en[F+1:1]),
    .num (ao_r),
    .den (ad_r),
    .quo (frac)
  );

  chsi_basis #(
    .FRAC_BITS (F)
  ) u_basis (
    .clk  (clk),
    .en   (en[F+4:F+2]),
    .frac (frac),
    .h00  (h00),
    .h10  (h10),
    .h01  (h01),
    .h11  (h11)
  );

  chsi_mac #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F)
  ) u_mac (
    .clk       (clk),
    .en        (en[F+6:F+5]),
    .h00       (h00),
    .h10       (h10),
    .h01       (h01),
    .h11       (h11),
    .tag       (side_r[SIDE_N].tag),
    .tsum      (side_r[SIDE_N].tsum),
    .v0        (side_r[SIDE_N].v0),
    .v1        (side_r[SIDE_N].v1),
    .p0        (side_r[SIDE_N].p0),
    .p1        (side_r[SIDE_N].p1),
    .value     (value),
    .in_range  (out_bus.in_range),
    .saturated (out_bus.saturated),
    .comp_out  (out_bus.component_out)
  );

  assign out_bus.interpolated_value = value;

`ifndef SYNTH
  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_bus.valid)
    else $error("output valid after reset");

  // Input is ready exactly when some stage is free or the output is drained.
  a_ready_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready == ((|(~vld_r)) || out_bus.ready))
    else $error("input ready does not match pipeline occupancy");

  // A full stage that was held keeps its beat.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((($past(vld_r) & ~$past(en)) & ~vld_r) == '0))
    else $error("held pipeline stage lost its beat");

  // Clipping only happens on an in-range result.
  a_sat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.saturated) |-> out_bus.in_range)
    else $error("saturated flag on an out-of-range result");
`endif

endmodule
